[design/udpck_pkg.sv]
// Shared types, constants and the checksum fold for the UDP/IPv4 checksum generator.
// No dependencies; used by every module of the block.
package udpck_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int REC_CNT_W  = 16;
    localparam int LEN_OUT_W  = 11;

    localparam logic [CFG_ADDR_W-1:0] REG_SRC_ADDR  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DST_ADDR  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SRC_PORT  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DST_PORT  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_TTL       = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_SERVICE   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_FLAGS_FRG = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_VER_IHL   = 3'd7;

    localparam logic [7:0]  TTL_RESET     = 8'd128;
    localparam logic [7:0]  VER_IHL_RESET = 8'h45;
    localparam logic [7:0]  UDP_PROTOCOL  = 8'h11;
    localparam logic [15:0] UDP_HDR_BYTES = 16'd8;
    localparam logic [15:0] IP_HDR_BYTES  = 16'd20;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  ttl;
        logic [7:0]  service;
        logic [15:0] flags_frag;
        logic [7:0]  ver_ihl;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{src_addr: 32'd0, dst_addr: 32'd0, sport: 16'd0,
                                   dport: 16'd0, ttl: TTL_RESET, service: 8'd0,
                                   flags_frag: 16'd0, ver_ihl: VER_IHL_RESET};

    // One finished packet handed from the front end to the back end
    typedef struct packed {
        logic [31:0]          sum;
        logic [REC_CNT_W-1:0] count;
        logic                 too_long;
    } pkt_rec_t;

    function automatic logic [15:0] fold_complement(input logic [31:0] s);
        logic [16:0] t;
        logic [16:0] u;
        t = {1'b0, s[31:16]} + {1'b0, s[15:0]};
        u = {16'd0, t[16]} + {1'b0, t[15:0]};
        return ~u[15:0];
    endfunction

endpackage

[design/udp_ipv4_header_checksum_gen_core.sv]
// Top level of the UDP/IPv4 header field and checksum generator: configuration
// registers, front end, record queue and back end. Depends on udpck_pkg and all udpck_ modules.
//
// Usage:
//   Input channel (s_): one UDP payload byte per item, s_last_byte marks the
//   packet's final byte. One byte is taken per cycle while the record queue
//   has room; bytes beyond MAX_PAYLOAD are dropped and flagged as too_long.
//   Result channel (m_): one item per packet with payload count, UDP length,
//   IPv4 total length, identification (1 for the first packet after reset),
//   IPv4 header checksum and UDP checksum.
//   Throughput: one byte per cycle while the record queue has room, one
//   result per cycle at most.
//   A four-entry queue of packet records sits between the byte accumulator
//   and the three-stage checksum pipeline; when m_ready is low the pipeline
//   holds, the queue fills, and s_ready drops only once four records wait.
//   Configuration (cfg_): write-only registers; the user writes them only when the block is idle (not enforced).
//   Reset (aresetn low, synchronous) clears the partial packet, queue,
//   pipeline, identification counter and loads the register defaults.
module udp_ipv4_header_checksum_gen_core #(
    parameter int MAX_PAYLOAD = 1472
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_payload_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [10:0] m_payload_count,
    output logic [10:0] m_udp_len_field,
    output logic [10:0] m_ip_total_len,
    output logic [15:0] m_ident_field,
    output logic [15:0] m_ip_header_sum,
    output logic [15:0] m_udp_sum,
    output logic        m_too_long
);

    udpck_pkg::cfg_t     cfg_reg, cfg_next;
    udpck_pkg::pkt_rec_t push_rec, pop_rec;
    logic                push, pop, fifo_empty, fifo_full;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                udpck_pkg::REG_SRC_ADDR:  cfg_next.src_addr   = cfg_wr_data;
                udpck_pkg::REG_DST_ADDR:  cfg_next.dst_addr   = cfg_wr_data;
                udpck_pkg::REG_SRC_PORT:  cfg_next.sport      = cfg_wr_data[15:0];
                udpck_pkg::REG_DST_PORT:  cfg_next.dport      = cfg_wr_data[15:0];
                udpck_pkg::REG_TTL:       cfg_next.ttl        = cfg_wr_data[7:0];
                udpck_pkg::REG_SERVICE:   cfg_next.service    = cfg_wr_data[7:0];
                udpck_pkg::REG_FLAGS_FRG: cfg_next.flags_frag = cfg_wr_data[15:0];
                udpck_pkg::REG_VER_IHL:   cfg_next.ver_ihl    = cfg_wr_data[7:0];
                default:                  cfg_next            = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= udpck_pkg::CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    udpck_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_payload_byte(s_payload_byte),
        .s_last_byte   (s_last_byte),
        .fifo_full     (fifo_full),
        .push          (push),
        .push_rec      (push_rec)
    );

    udpck_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_rec(push_rec),
        .pop     (pop),
        .pop_rec (pop_rec),
        .empty   (fifo_empty),
        .full    (fifo_full)
    );

    udpck_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .rec_avail      (!fifo_empty),
        .rec            (pop_rec),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_payload_count(m_payload_count),
        .m_udp_len_field(m_udp_len_field),
        .m_ip_total_len (m_ip_total_len),
        .m_ident_field  (m_ident_field),
        .m_ip_header_sum(m_ip_header_sum),
        .m_udp_sum      (m_udp_sum),
        .m_too_long     (m_too_long)
    );

endmodule

[design/udpck_front.sv]
// Front end: accepts payload bytes, pairs them into big-endian words and sums them.
// Pushes one packet record per last byte. Depends on udpck_pkg.
module udpck_front #(
    parameter int MAX_PAYLOAD = 1472
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_payload_byte,
    input  logic                s_last_byte,
    input  logic                fifo_full,
    output logic                push,
    output udpck_pkg::pkt_rec_t push_rec
);

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PAYLOAD);

    logic [31:0]      sum_reg, sum_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       held_reg, held_next;
    logic             odd_reg, odd_next;
    logic             ovf_reg, ovf_next;

    logic             accept;
    logic             counted;
    logic [15:0]      word;
    logic [31:0]      sum_with;
    logic [CNT_W-1:0] cnt_new;
    logic             ovf_new;

    assign s_ready = !fifo_full;
    assign accept  = s_valid && s_ready;
    assign counted = cnt_reg < MAX_CNT;

    always_comb begin
        if (counted) begin
            if (odd_reg) begin
                word = {held_reg, s_payload_byte};
            end else if (s_last_byte) begin
                word = {s_payload_byte, 8'd0};
            end else begin
                word = 16'd0;
            end
        end else if (odd_reg && s_last_byte) begin
            word = {held_reg, 8'd0};
        end else begin
            word = 16'd0;
        end
    end

    assign sum_with = sum_reg + {16'd0, word};
    assign cnt_new  = counted ? cnt_reg + CNT_W'(1) : cnt_reg;
    assign ovf_new  = ovf_reg || !counted;

    assign push              = accept && s_last_byte;
    assign push_rec.sum      = sum_with;
    assign push_rec.count    = udpck_pkg::REC_CNT_W'(cnt_new);
    assign push_rec.too_long = ovf_new;

    always_comb begin
        sum_next  = sum_reg;
        cnt_next  = cnt_reg;
        held_next = held_reg;
        odd_next  = odd_reg;
        ovf_next  = ovf_reg;
        if (accept) begin
            if (s_last_byte) begin
                sum_next  = 32'd0;
                cnt_next  = '0;
                held_next = 8'd0;
                odd_next  = 1'b0;
                ovf_next  = 1'b0;
            end else begin
                sum_next = sum_with;
                cnt_next = cnt_new;
                ovf_next = ovf_new;
                if (counted) begin
                    odd_next = !odd_reg;
                    if (!odd_reg) begin
                        held_next = s_payload_byte;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg  <= 32'd0;
            cnt_reg  <= '0;
            held_reg <= 8'd0;
            odd_reg  <= 1'b0;
            ovf_reg  <= 1'b0;
        end else begin
            sum_reg  <= sum_next;
            cnt_reg  <= cnt_next;
            held_reg <= held_next;
            odd_reg  <= odd_next;
            ovf_reg  <= ovf_next;
        end
    end

endmodule

[design/udpck_fifo.sv]
// Four-entry queue of packet records between the front and back ends.
// Depends on udpck_pkg.
module udpck_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  udpck_pkg::pkt_rec_t push_rec,
    input  logic                pop,
    output udpck_pkg::pkt_rec_t pop_rec,
    output logic                empty,
    output logic                full
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    udpck_pkg::pkt_rec_t mem_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]      fill_reg, fill_next;
    logic                do_push, do_pop;

    assign empty   = fill_reg == '0;
    assign full    = fill_reg == (PTR_W+1)'(DEPTH);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_rec = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + (PTR_W+1)'(1);
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - (PTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

[design/udpck_back.sv]
// Back end: three-stage pipeline that builds lengths, identification and both checksums
// from a packet record. Depends on udpck_pkg.
module udpck_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  udpck_pkg::cfg_t     cfg,
    input  logic                rec_avail,
    input  udpck_pkg::pkt_rec_t rec,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [10:0]         m_payload_count,
    output logic [10:0]         m_udp_len_field,
    output logic [10:0]         m_ip_total_len,
    output logic [15:0]         m_ident_field,
    output logic [15:0]         m_ip_header_sum,
    output logic [15:0]         m_udp_sum,
    output logic                m_too_long
);

    logic        adv;
    logic [15:0] ident_reg;

    // stage 1
    logic        v1_reg;
    logic [31:0] sum1_reg;
    logic [15:0] cnt1_reg, udp_len1_reg, ip_len1_reg, ident1_reg;
    logic [17:0] addr1_reg;
    logic        tl1_reg;

    // stage 2
    logic        v2_reg;
    logic [31:0] ip_s2_reg, udp_s2_reg;
    logic [15:0] cnt2_reg, udp_len2_reg, ip_len2_reg, ident2_reg;
    logic        tl2_reg;

    // output stage
    logic        v3_reg;
    logic [15:0] ip_fold, udp_fold;

    assign adv = !v3_reg || m_ready;
    assign pop = adv && rec_avail;

    assign ip_fold  = udpck_pkg::fold_complement(ip_s2_reg);
    assign udp_fold = udpck_pkg::fold_complement(udp_s2_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            ident_reg <= 16'd0;
        end else begin
            if (adv) begin
                v1_reg <= rec_avail;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
            end
            if (pop) begin
                ident_reg <= ident_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sum1_reg     <= rec.sum;
            cnt1_reg     <= rec.count;
            tl1_reg      <= rec.too_long;
            udp_len1_reg <= rec.count + udpck_pkg::UDP_HDR_BYTES;
            ip_len1_reg  <= rec.count + udpck_pkg::UDP_HDR_BYTES + udpck_pkg::IP_HDR_BYTES;
            ident1_reg   <= ident_reg + 16'd1;
            addr1_reg    <= 18'(cfg.src_addr[31:16]) + 18'(cfg.src_addr[15:0])
                          + 18'(cfg.dst_addr[31:16]) + 18'(cfg.dst_addr[15:0]);

            ip_s2_reg    <= 32'({cfg.ver_ihl, cfg.service}) + 32'(ip_len1_reg)
                          + 32'(ident1_reg) + 32'(cfg.flags_frag)
                          + 32'({cfg.ttl, udpck_pkg::UDP_PROTOCOL}) + 32'(addr1_reg);
            udp_s2_reg   <= sum1_reg + 32'(addr1_reg) + 32'(udpck_pkg::UDP_PROTOCOL)
                          + 32'(udp_len1_reg) + 32'(udp_len1_reg)
                          + 32'(cfg.sport) + 32'(cfg.dport);
            cnt2_reg     <= cnt1_reg;
            udp_len2_reg <= udp_len1_reg;
            ip_len2_reg  <= ip_len1_reg;
            ident2_reg   <= ident1_reg;
            tl2_reg      <= tl1_reg;

            m_payload_count <= cnt2_reg[10:0];
            m_udp_len_field <= udp_len2_reg[10:0];
            m_ip_total_len  <= ip_len2_reg[10:0];
            m_ident_field   <= ident2_reg;
            m_ip_header_sum <= ip_fold;
            m_udp_sum       <= (udp_fold == 16'd0) ? 16'hffff : udp_fold;
            m_too_long      <= tl2_reg;
        end
    end

    assign m_valid = v3_reg;

endmodule

[sim/tb.sv]
// Self-checking testbench for udp_ipv4_header_checksum_gen_core: streams payload bytes,
// predicts lengths, identification and both checksums, and checks every result item.
// Depends on udpck_pkg and the block's RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_BYTES   = 1472;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 12;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_item_t;

    typedef struct packed {
        logic [10:0] count;
        logic [10:0] udp_len;
        logic [10:0] ip_len;
        logic [15:0] ident;
        logic [15:0] ip_sum;
        logic [15:0] udp_sum;
        logic        too_long;
    } pkt_fields_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [2:0]  cfg_index   = '0;
    logic [31:0] cfg_wr_data = '0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_payload_byte = '0;
    logic        s_last_byte    = 1'b0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [10:0] m_payload_count;
    logic [10:0] m_udp_len_field;
    logic [10:0] m_ip_total_len;
    logic [15:0] m_ident_field;
    logic [15:0] m_ip_header_sum;
    logic [15:0] m_udp_sum;
    logic        m_too_long;

    udp_ipv4_header_checksum_gen_core i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_payload_byte  (s_payload_byte),
        .s_last_byte     (s_last_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_payload_count (m_payload_count),
        .m_udp_len_field (m_udp_len_field),
        .m_ip_total_len  (m_ip_total_len),
        .m_ident_field   (m_ident_field),
        .m_ip_header_sum (m_ip_header_sum),
        .m_udp_sum       (m_udp_sum),
        .m_too_long      (m_too_long)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    byte_item_t  pending_bytes[$];
    pkt_fields_t expected_pkts[$];

    udpck_pkg::cfg_t cfg_mirror;
    logic [31:0] pkt_sum;
    logic [10:0] pkt_count;
    logic [7:0]  hi_byte;
    logic        half_word;
    logic        pkt_overflow;
    logic [15:0] ident_cnt;

    bit idling_on     = 1'b1;
    int error_count   = 0;
    int bytes_sent    = 0;
    int pkts_checked  = 0;
    int oversized     = 0;
    int settings_used = 1;
    int cycle_count   = 0;

    function automatic logic [15:0] ones_fold(input logic [31:0] s);
        logic [31:0] t;
        t = (s >> 16) + (s & 32'hffff);
        t = (t >> 16) + (t & 32'hffff);
        return ~t[15:0];
    endfunction

    // Pseudo-header plus UDP header words, checksum field taken as zero
    function automatic logic [31:0] udp_header_sum(input udpck_pkg::cfg_t c,
                                                   input logic [15:0] ulen);
        return 32'(c.src_addr[31:16]) + 32'(c.src_addr[15:0])
             + 32'(c.dst_addr[31:16]) + 32'(c.dst_addr[15:0])
             + 32'(udpck_pkg::UDP_PROTOCOL) + 32'(ulen) + 32'(c.sport) + 32'(c.dport)
             + 32'(ulen);
    endfunction

    task automatic absorb_byte(input byte_item_t it);
        logic [15:0] ulen;
        logic [15:0] iplen;
        logic [31:0] s;
        pkt_fields_t r;
        if (pkt_count < 11'(MAX_BYTES)) begin
            if (half_word) begin
                pkt_sum   = pkt_sum + {16'd0, hi_byte, it.data};
                half_word = 1'b0;
            end else begin
                hi_byte   = it.data;
                half_word = 1'b1;
            end
            pkt_count = pkt_count + 11'd1;
        end else begin
            pkt_overflow = 1'b1;
        end
        if (it.last) begin
            ulen      = 16'(pkt_count) + udpck_pkg::UDP_HDR_BYTES;
            iplen     = ulen + udpck_pkg::IP_HDR_BYTES;
            ident_cnt = ident_cnt + 16'd1;
            s = 32'({cfg_mirror.ver_ihl, cfg_mirror.service}) + 32'(iplen) + 32'(ident_cnt)
              + 32'(cfg_mirror.flags_frag) + 32'({cfg_mirror.ttl, udpck_pkg::UDP_PROTOCOL})
              + 32'(cfg_mirror.src_addr[31:16]) + 32'(cfg_mirror.src_addr[15:0])
              + 32'(cfg_mirror.dst_addr[31:16]) + 32'(cfg_mirror.dst_addr[15:0]);
            r.ip_sum = ones_fold(s);
            s = pkt_sum + (half_word ? {16'd0, hi_byte, 8'd0} : 32'd0)
              + udp_header_sum(cfg_mirror, ulen);
            r.udp_sum  = ones_fold(s);
            if (r.udp_sum == 16'd0) r.udp_sum = 16'hffff;
            r.count    = pkt_count;
            r.udp_len  = ulen[10:0];
            r.ip_len   = iplen[10:0];
            r.ident    = ident_cnt;
            r.too_long = pkt_overflow;
            if (pkt_overflow) oversized++;
            expected_pkts.push_back(r);
            pkt_sum      = '0;
            pkt_count    = '0;
            hi_byte      = '0;
            half_word    = 1'b0;
            pkt_overflow = 1'b0;
        end
    endtask

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            error_count++;
        end
    endfunction

    // Sender
    byte_item_t in_flight;
    int         gap_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                absorb_byte(in_flight);
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_bytes.size() > 0) begin
                    in_flight = pending_bytes.pop_front();
                    s_valid        <= 1'b1;
                    s_payload_byte <= in_flight.data;
                    s_last_byte    <= in_flight.last;
                    if (idling_on && $urandom_range(0, 15) == 0) begin
                        gap_left = $urandom_range(1, 13);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver and checker
    int          stall_left = 0;
    pkt_fields_t want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_pkts.size() == 0) begin
                    $error("result item with no packet outstanding");
                    error_count++;
                end else begin
                    want = expected_pkts.pop_front();
                    check_field("payload_count", 32'(want.count), 32'(m_payload_count));
                    check_field("udp_len_field", 32'(want.udp_len), 32'(m_udp_len_field));
                    check_field("ip_total_len", 32'(want.ip_len), 32'(m_ip_total_len));
                    check_field("ident_field", 32'(want.ident), 32'(m_ident_field));
                    check_field("ip_header_sum", 32'(want.ip_sum), 32'(m_ip_header_sum));
                    check_field("udp_sum", 32'(want.udp_sum), 32'(m_udp_sum));
                    check_field("too_long", 32'(want.too_long), 32'(m_too_long));
                    pkts_checked++;
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (idling_on && $urandom_range(0, 9) == 0) begin
                    stall_left = $urandom_range(1, 13);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d packets outstanding",
                     cycle_count, expected_pkts.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // fill < 0 gives random bytes
    task automatic add_packet(input int len, input int fill);
        byte_item_t it;
        for (int i = 0; i < len; i++) begin
            it.data = (fill < 0) ? 8'($urandom) : 8'(fill);
            it.last = (i == len - 1);
            pending_bytes.push_back(it);
        end
        bytes_sent += len;
    endtask

    // Two-byte packet whose UDP checksum computes to zero
    task automatic add_zero_sum_packet();
        logic [15:0] folded;
        logic [15:0] w;
        byte_item_t  it;
        folded  = ~ones_fold(udp_header_sum(cfg_mirror, 16'd10));
        w       = 16'hffff - folded;
        it.data = w[15:8];
        it.last = 1'b0;
        pending_bytes.push_back(it);
        it.data = w[7:0];
        it.last = 1'b1;
        pending_bytes.push_back(it);
        bytes_sent += 2;
    endtask

    task automatic add_random_traffic(input int nbytes);
        int sent;
        int r;
        int len;
        sent = 0;
        while (sent < nbytes) begin
            r = $urandom_range(0, 99);
            if (r < 80)      len = $urandom_range(1, 12);
            else if (r < 97) len = $urandom_range(13, 64);
            else             len = $urandom_range(65, 300);
            add_packet(len, -1);
            sent += len;
        end
    endtask

    task automatic wait_idle();
        while (pending_bytes.size() != 0 || s_valid || expected_pkts.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        case (idx)
            udpck_pkg::REG_SRC_ADDR:  cfg_mirror.src_addr   = data;
            udpck_pkg::REG_DST_ADDR:  cfg_mirror.dst_addr   = data;
            udpck_pkg::REG_SRC_PORT:  cfg_mirror.sport      = data[15:0];
            udpck_pkg::REG_DST_PORT:  cfg_mirror.dport      = data[15:0];
            udpck_pkg::REG_TTL:       cfg_mirror.ttl        = data[7:0];
            udpck_pkg::REG_SERVICE:   cfg_mirror.service    = data[7:0];
            udpck_pkg::REG_FLAGS_FRG: cfg_mirror.flags_frag = data[15:0];
            udpck_pkg::REG_VER_IHL:   cfg_mirror.ver_ihl    = data[7:0];
            default: ;
        endcase
    endtask

    // mode 0: all ones, 1: all zeros, 2: random
    task automatic load_settings(input int mode);
        logic [31:0] v;
        for (int i = 0; i < 8; i++) begin
            case (mode)
                0:       v = 32'hffff_ffff;
                1:       v = 32'h0;
                default: v = $urandom;
            endcase
            write_reg(3'(i), v);
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    initial begin
        cfg_mirror   = udpck_pkg::CFG_RESET;
        pkt_sum      = '0;
        pkt_count    = '0;
        hi_byte      = '0;
        half_word    = 1'b0;
        pkt_overflow = 1'b0;
        ident_cnt    = '0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed packets on reset settings
        add_packet(1, 8'hff);
        add_packet(2, 8'h00);
        add_packet(3, 8'hff);
        add_packet(4, -1);
        add_zero_sum_packet();
        add_packet(64, 8'hff);
        add_packet(1, 8'h00);
        wait_idle();

        for (int phase = 0; phase < 7; phase++) begin
            load_settings(phase < 2 ? phase : 2);
            if (phase == 6) idling_on = 1'b0;
            add_zero_sum_packet();
            add_packet(1, -1);
            add_random_traffic(105);
            wait_idle();
        end

        $display("checked %0d packets from %0d bytes, %0d oversized, %0d register settings",
                 pkts_checked, bytes_sent, oversized, settings_used);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[udp_ipv4_header_checksum_gen_core.f]
design/udpck_pkg.sv
design/udpck_front.sv
design/udpck_fifo.sv
design/udpck_back.sv
design/udp_ipv4_header_checksum_gen_core.sv
sim/tb.sv
